// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of i_clk, off while reset is low.
`define SAA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen.
`define SAA_NEVER(lbl, expr, msg) \
    `SAA_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/saa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saa_pkg
// Types, codes and defaults of the shelf atlas allocator.
// ----------------------------------------------------------------------------
package saa_pkg;

    // Internal height/y width, covers a height limit of up to 65536.
    localparam int HW = 17;
    localparam int XW = 12;
    localparam int WW = 13;
    localparam int CW = 11;      // row reservation count

    localparam int DEF_FREE_ENTRIES     = 64;
    localparam int DEF_RESERVED_ENTRIES = 64;
    localparam int DEF_ROW_ENTRIES      = 64;
    localparam int DEF_MAX_HEIGHT       = 16384;

    localparam logic [WW-1:0] MAX_WIDTH   = 13'd4096;
    localparam logic [12:0]   ATLAS_W_RST = 13'd1024;
    localparam logic [14:0]   INIT_H_RST  = 15'd1024;

    localparam logic [1:0] OP_RESERVE = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_GREW    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_LIMIT   = 3'd4;

    localparam logic CFG_ATLAS_WIDTH = 1'b0;
    localparam logic CFG_INIT_HEIGHT = 1'b1;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [HW-1:0] y;
        logic [WW-1:0] w;
        logic [HW-1:0] h;
    } t_blk;

    typedef struct packed {
        logic [HW-1:0] y;
        logic [CW-1:0] cnt;
    } t_row;

    typedef struct packed {
        logic [11:0] x;
        logic [13:0] y;
        logic [14:0] h;
        logic [14:0] bh;
        logic [2:0]  st;
    } t_res;

    localparam int BLK_W = $bits(t_blk);
    localparam int ROW_W = $bits(t_row);

    function automatic t_res res_make(input logic [XW-1:0] x, input logic [HW-1:0] y,
                                      input logic [HW-1:0] h, input logic [HW-1:0] bh,
                                      input logic [2:0] st);
        t_res r;
        r.x  = x;
        r.y  = y[13:0];
        r.h  = h[14:0];
        r.bh = bh[14:0];
        r.st = st;
        return r;
    endfunction

endpackage

// ===== rtl/shelf_atlas_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shelf_atlas_allocator_top
// Shelf allocator for a 2-D image buffer: reserve, free and clear of blocks.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low; busy stays high
// until the command is done. Every command gives exactly one result, shown for
// a single cycle with o_strobe; the receiver cannot stall it, so capture it
// then. A small sequencer walks the free list, the row table and the reserved
// table one entry per cycle through their RAM read ports: a reserve scans the
// free list and the rows in use, and the free list again from the taken block
// on when a block is taken out of the list; a free scans the whole reserved
// table and the rows in use, and the free list as well when it merges a row.
// The search for a free reserved slot runs alongside the reserve scans, one
// entry per cycle, and a reserve does not commit until it has found a free
// slot or passed the whole table. A clear, a reset or a configuration write
// passes through the clear state, during which busy is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shelf_atlas_allocator_top
    import saa_pkg::*;
#(
    parameter int FREE_ENTRIES     = DEF_FREE_ENTRIES,
    parameter int RESERVED_ENTRIES = DEF_RESERVED_ENTRIES,
    parameter int ROW_ENTRIES      = DEF_ROW_ENTRIES,
    parameter int MAX_HEIGHT       = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [12:0] i_req_width,
    input  logic [14:0] i_req_height,
    input  logic [11:0] i_addr_x,
    input  logic [13:0] i_addr_y,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    output logic        o_strobe,
    output logic [11:0] o_block_x,
    output logic [13:0] o_block_y,
    output logic [14:0] o_block_height,
    output logic [14:0] o_buffer_height,
    output logic [2:0]  o_status
);

    localparam int FIW = $clog2(FREE_ENTRIES);
    localparam int RIW = $clog2(RESERVED_ENTRIES);
    localparam int WIW = $clog2(ROW_ENTRIES);
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int RCW = $clog2(RESERVED_ENTRIES + 1);
    localparam int UCW = $clog2(ROW_ENTRIES + 1);
    localparam int PW0 = (FCW > RCW) ? FCW : RCW;
    localparam int PW  = (PW0 > UCW) ? PW0 : UCW;

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLEAR  = 5'd1;
    localparam logic [4:0] S_RFSCAN = 5'd2;
    localparam logic [4:0] S_RDEC   = 5'd3;
    localparam logic [4:0] S_RROW   = 5'd4;
    localparam logic [4:0] S_RCHK   = 5'd5;
    localparam logic [4:0] S_RREM   = 5'd6;
    localparam logic [4:0] S_RAPPH  = 5'd7;
    localparam logic [4:0] S_RAPPV  = 5'd8;
    localparam logic [4:0] S_RROWH  = 5'd9;
    localparam logic [4:0] S_RROWB  = 5'd10;
    localparam logic [4:0] S_FSCAN  = 5'd11;
    localparam logic [4:0] S_FDEC   = 5'd12;
    localparam logic [4:0] S_FROW   = 5'd13;
    localparam logic [4:0] S_FROWD  = 5'd14;
    localparam logic [4:0] S_FCMP   = 5'd15;
    localparam logic [4:0] S_FAPP   = 5'd16;

    // control state
    logic [4:0]                  r_state, n_state;
    logic [12:0]                 r_atlas_w, n_atlas_w;
    logic [14:0]                 r_init_h, n_init_h;
    logic [FCW-1:0]              r_fc, n_fc;
    logic [UCW-1:0]              r_ru, n_ru;
    logic [RESERVED_ENTRIES-1:0] r_valid, n_valid;
    logic [HW-1:0]               r_hi, n_hi;
    logic [HW-1:0]               r_cur_h, n_cur_h;
    logic                        r_strobe, n_strobe;
    logic                        r_dv, n_dv;

    // payload / working registers
    logic           r_clr_out, n_clr_out;
    logic [WW-1:0]  r_w, n_w;
    logic [HW-1:0]  r_h, n_h;
    logic [XW-1:0]  r_ax, n_ax;
    logic [HW-1:0]  r_ay, n_ay;
    logic [PW-1:0]  r_ptr, n_ptr;
    logic [PW-1:0]  r_dptr, n_dptr;
    logic           r_fit_ok, n_fit_ok;
    logic [FIW-1:0] r_fit_idx, n_fit_idx;
    t_blk           r_fit, n_fit;
    logic           r_ext_ok, n_ext_ok;
    logic [FIW-1:0] r_ext_idx, n_ext_idx;
    t_blk           r_ext, n_ext;
    t_blk           r_blk, n_blk;
    logic [FIW-1:0] r_idx, n_idx;
    logic [HW-1:0]  r_newh, n_newh;
    logic           r_grew, n_grew;
    logic           r_addnew, n_addnew;
    logic           r_sh, n_sh;
    logic           r_sv, n_sv;
    logic [HW-1:0]  r_gh, n_gh;
    logic [WW-1:0]  r_gw, n_gw;
    logic           r_rb_ok, n_rb_ok;
    logic [WIW-1:0] r_rb_idx, n_rb_idx;
    logic [CW-1:0]  r_rb_cnt, n_rb_cnt;
    logic           r_rh_ok, n_rh_ok;
    logic [WIW-1:0] r_rh_idx, n_rh_idx;
    logic [RCW-1:0] r_vptr, n_vptr;
    logic           r_vdone, n_vdone;
    logic           r_slot_ok, n_slot_ok;
    logic [RIW-1:0] r_slot, n_slot;
    logic           r_hit_ok, n_hit_ok;
    logic [RIW-1:0] r_hit_idx, n_hit_idx;
    t_blk           r_hit, n_hit;
    logic [HW-1:0]  r_rowh, n_rowh;
    logic [FCW-1:0] r_wr, n_wr;
    t_res           r_res, n_res;

    // RAM ports
    logic             fl_we, rw_we, rs_we;
    logic [FIW-1:0]   fl_waddr;
    logic [WIW-1:0]   rw_waddr;
    logic [RIW-1:0]   rs_waddr;
    t_blk             fl_wdata, rs_wdata;
    t_row             rw_wdata;
    logic [BLK_W-1:0] fl_rdata, rs_rdata;
    logic [ROW_W-1:0] rw_rdata;
    t_blk             fl_rd, rs_rd;
    t_row             rw_rd;

    logic [WW-1:0]  w_eff_w;
    logic [HW-1:0]  w_eff_h;
    logic [HW-1:0]  w_init17;
    logic [PW-1:0]  w_lim;
    logic           w_issue;
    logic           w_done;

    assign fl_rd = t_blk'(fl_rdata);
    assign rs_rd = t_blk'(rs_rdata);
    assign rw_rd = t_row'(rw_rdata);

    saa_ram #(.WIDTH(BLK_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_raddr (r_ptr[FIW-1:0]),
        .o_rdata (fl_rdata)
    );

    saa_ram #(.WIDTH(BLK_W), .DEPTH(RESERVED_ENTRIES)) u_rsv_ram (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (rs_waddr),
        .i_wdata (rs_wdata),
        .i_raddr (r_ptr[RIW-1:0]),
        .o_rdata (rs_rdata)
    );

    saa_ram #(.WIDTH(ROW_W), .DEPTH(ROW_ENTRIES)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (rw_we),
        .i_waddr (rw_waddr),
        .i_wdata (rw_wdata),
        .i_raddr (r_ptr[WIW-1:0]),
        .o_rdata (rw_rdata)
    );

    // Effective register values: zero reads as one, clamp to the limits.
    assign w_init17 = HW'(r_init_h);
    always_comb begin
        if (r_atlas_w == '0) begin
            w_eff_w = WW'(1);
        end else if (r_atlas_w > MAX_WIDTH) begin
            w_eff_w = MAX_WIDTH;
        end else begin
            w_eff_w = r_atlas_w;
        end
        if (w_init17 == '0) begin
            w_eff_h = HW'(1);
        end else if (w_init17 > HW'(MAX_HEIGHT)) begin
            w_eff_h = HW'(MAX_HEIGHT);
        end else begin
            w_eff_h = w_init17;
        end
    end

    // Scan limit for the table walked in the current state.
    always_comb begin
        case (r_state)
            S_RFSCAN, S_RREM, S_FCMP: w_lim = PW'(r_fc);
            S_RROW, S_FROW:           w_lim = PW'(r_ru);
            S_FSCAN:                  w_lim = PW'(RESERVED_ENTRIES);
            default:                  w_lim = '0;
        endcase
    end
    assign w_issue = (r_ptr < w_lim);
    assign w_done  = !r_dv && !w_issue;

    always_comb begin
        t_blk             v_blk;
        logic [HW:0]      v_g;
        logic [HW-1:0]    v_newh;
        logic [HW-1:0]    v_delta;
        logic             v_sh;
        logic             v_sv;
        logic             v_limit;
        logic [FCW:0]     v_nf;
        logic [UCW:0]     v_nr;
        logic [HW:0]      v_top;
        logic [FIW-1:0]   v_di;
        logic [2:0]       v_st;

        n_state   = r_state;   n_atlas_w = r_atlas_w; n_init_h  = r_init_h;
        n_fc      = r_fc;      n_ru      = r_ru;      n_valid   = r_valid;
        n_hi      = r_hi;      n_cur_h   = r_cur_h;   n_strobe  = 1'b0;
        n_dv      = r_dv;      n_clr_out = r_clr_out;
        n_w       = r_w;       n_h       = r_h;       n_ax      = r_ax;
        n_ay      = r_ay;      n_ptr     = r_ptr;     n_dptr    = r_dptr;
        n_fit_ok  = r_fit_ok;  n_fit_idx = r_fit_idx; n_fit     = r_fit;
        n_ext_ok  = r_ext_ok;  n_ext_idx = r_ext_idx; n_ext     = r_ext;
        n_blk     = r_blk;     n_idx     = r_idx;     n_newh    = r_newh;
        n_grew    = r_grew;    n_addnew  = r_addnew;  n_sh      = r_sh;
        n_sv      = r_sv;      n_gh      = r_gh;      n_gw      = r_gw;
        n_rb_ok   = r_rb_ok;   n_rb_idx  = r_rb_idx;  n_rb_cnt  = r_rb_cnt;
        n_rh_ok   = r_rh_ok;   n_rh_idx  = r_rh_idx;
        n_vptr    = r_vptr;    n_vdone   = r_vdone;
        n_slot_ok = r_slot_ok; n_slot    = r_slot;
        n_hit_ok  = r_hit_ok;  n_hit_idx = r_hit_idx; n_hit     = r_hit;
        n_rowh    = r_rowh;    n_wr      = r_wr;      n_res     = r_res;

        fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0;
        rw_we = 1'b0; rw_waddr = '0; rw_wdata = '0;
        rs_we = 1'b0; rs_waddr = '0; rs_wdata = '0;

        v_blk   = r_blk;
        v_sh    = 1'b0;
        v_sv    = 1'b0;
        v_limit = 1'b0;
        v_di    = r_dptr[FIW-1:0];
        v_st    = ST_OK;

        // growth target: floor(height * 5 / 4), capped
        v_g = {1'b0, r_cur_h} + (HW + 1)'(r_cur_h >> 2);
        if (v_g > (HW + 1)'(MAX_HEIGHT)) begin
            v_g = (HW + 1)'(MAX_HEIGHT);
        end
        v_newh  = HW'(v_g);
        v_delta = v_newh - r_cur_h;

        v_nf  = {1'b0, r_fc} + (FCW + 1)'(r_sh) + (FCW + 1)'(r_sv);
        v_nr  = {1'b0, r_ru} + (UCW + 1)'(!r_rb_ok) + (UCW + 1)'(r_sh && !r_rh_ok);
        v_top = {1'b0, r_blk.y} + {1'b0, r_gh};

        // shared scan pointer: one RAM read issued per cycle
        if (r_state inside {S_RFSCAN, S_RREM, S_FCMP, S_RROW, S_FROW, S_FSCAN}) begin
            n_ptr  = w_issue ? r_ptr + PW'(1) : r_ptr;
            n_dv   = w_issue;
            n_dptr = r_ptr;
        end

        // free reserved slot search runs alongside the reserve scans
        if (r_state inside {S_RFSCAN, S_RDEC, S_RROW, S_RCHK} && !r_vdone) begin
            if (!r_valid[r_vptr[RIW-1:0]]) begin
                n_slot_ok = 1'b1;
                n_slot    = r_vptr[RIW-1:0];
                n_vdone   = 1'b1;
            end else if (r_vptr == RCW'(RESERVED_ENTRIES - 1)) begin
                n_vdone = 1'b1;
            end
            n_vptr = r_vptr + RCW'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    if (i_cfg_idx == CFG_ATLAS_WIDTH) begin
                        n_atlas_w = i_cfg_data[12:0];
                    end else begin
                        n_init_h = i_cfg_data;
                    end
                    n_clr_out = 1'b0;
                    n_state   = S_CLEAR;
                end else if (start) begin
                    n_ax    = i_addr_x;
                    n_ay    = HW'(i_addr_y);
                    if (i_req_width == '0) begin
                        n_w = WW'(1);
                    end else if (i_req_width > w_eff_w) begin
                        n_w = w_eff_w;
                    end else begin
                        n_w = i_req_width;
                    end
                    n_h = (i_req_height == '0) ? HW'(1) : HW'(i_req_height);
                    n_ptr = '0;
                    n_dv  = 1'b0;
                    case (i_opcode)
                        OP_RESERVE: begin
                            n_fit_ok  = 1'b0;
                            n_ext_ok  = 1'b0;
                            n_vptr    = '0;
                            n_vdone   = 1'b0;
                            n_slot_ok = 1'b0;
                            n_state   = S_RFSCAN;
                        end
                        OP_FREE: begin
                            n_hit_ok = 1'b0;
                            n_state  = S_FSCAN;
                        end
                        OP_CLEAR: begin
                            n_clr_out = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        default: begin
                            n_res    = res_make('0, '0, '0, r_cur_h, ST_OK);
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            // one full-width block, one empty row at y 0
            S_CLEAR: begin
                fl_we      = 1'b1;
                fl_waddr   = '0;
                fl_wdata.x = '0;
                fl_wdata.y = '0;
                fl_wdata.w = w_eff_w;
                fl_wdata.h = w_eff_h;
                rw_we      = 1'b1;
                rw_waddr   = '0;
                rw_wdata   = '0;
                n_valid    = '0;
                n_fc       = FCW'(1);
                n_ru       = UCW'(1);
                n_hi       = '0;
                n_cur_h    = w_eff_h;
                if (r_clr_out) begin
                    n_res    = res_make('0, '0, '0, w_eff_h, ST_OK);
                    n_strobe = 1'b1;
                end
                n_state = S_IDLE;
            end

            // first fit, and first block touching the top edge
            S_RFSCAN: begin
                if (r_dv) begin
                    if (!r_fit_ok && fl_rd.w >= r_w && fl_rd.h >= r_h) begin
                        n_fit_ok  = 1'b1;
                        n_fit_idx = v_di;
                        n_fit     = fl_rd;
                    end
                    if (!r_ext_ok && fl_rd.x == '0 && fl_rd.w == w_eff_w &&
                        ({1'b0, fl_rd.y} + {1'b0, fl_rd.h}) == {1'b0, r_cur_h}) begin
                        n_ext_ok  = 1'b1;
                        n_ext_idx = v_di;
                        n_ext     = fl_rd;
                    end
                end
                if (w_done) begin
                    n_state = S_RDEC;
                end
            end

            S_RDEC: begin
                n_addnew = 1'b0;
                if (r_fit_ok) begin
                    v_blk  = r_fit;
                    n_idx  = r_fit_idx;
                    n_grew = 1'b0;
                    n_newh = r_cur_h;
                end else if (r_ext_ok) begin
                    v_blk.x = '0;
                    v_blk.y = r_ext.y;
                    v_blk.w = w_eff_w;
                    v_blk.h = r_ext.h + v_delta;
                    n_idx   = r_ext_idx;
                    n_grew  = 1'b1;
                    n_newh  = v_newh;
                end else if (v_delta != '0) begin
                    // new block starts at the top of the highest reservation
                    v_blk.x  = '0;
                    v_blk.y  = r_hi;
                    v_blk.w  = w_eff_w;
                    v_blk.h  = v_delta;
                    n_addnew = 1'b1;
                    n_grew   = 1'b1;
                    n_newh   = v_newh;
                end else begin
                    v_limit = 1'b1;
                end
                v_sh  = (v_blk.h > r_h) && (v_blk.x == '0) && (v_blk.w == w_eff_w);
                v_sv  = (v_blk.w > r_w);
                n_blk = v_blk;
                n_sh  = v_sh;
                n_sv  = v_sv;
                n_gh  = v_sh ? r_h : v_blk.h;
                n_gw  = v_sv ? r_w : v_blk.w;
                if (v_limit) begin
                    n_res    = res_make('0, '0, '0, r_cur_h, ST_LIMIT);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = '0;
                    n_dv    = 1'b0;
                    n_rb_ok = 1'b0;
                    n_rh_ok = 1'b0;
                    n_state = S_RROW;
                end
            end

            // rows at the block start and at the height split
            S_RROW: begin
                if (r_dv) begin
                    if (!r_rb_ok && rw_rd.y == r_blk.y) begin
                        n_rb_ok  = 1'b1;
                        n_rb_idx = r_dptr[WIW-1:0];
                        n_rb_cnt = rw_rd.cnt;
                    end
                    if (!r_rh_ok && rw_rd.y == r_blk.y + r_h) begin
                        n_rh_ok  = 1'b1;
                        n_rh_idx = r_dptr[WIW-1:0];
                    end
                end
                if (w_done) begin
                    n_state = S_RCHK;
                end
            end

            // capacity check, then commit
            S_RCHK: begin
                if (r_vdone) begin
                    if (v_nf > (FCW + 1)'(FREE_ENTRIES) + (FCW + 1)'(!r_addnew) ||
                        v_nr > (UCW + 1)'(ROW_ENTRIES) || !r_slot_ok) begin
                        n_res    = res_make('0, '0, '0, r_cur_h, ST_FULL);
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_cur_h = r_newh;
                        if (!r_addnew) begin
                            n_ptr   = PW'(r_idx) + PW'(1);
                            n_dv    = 1'b0;
                            n_state = S_RREM;
                        end else begin
                            n_state = S_RAPPH;
                        end
                    end
                end
            end

            // close the gap left by the taken block
            S_RREM: begin
                if (r_dv) begin
                    fl_we    = 1'b1;
                    fl_waddr = v_di - FIW'(1);
                    fl_wdata = fl_rd;
                end
                if (w_done) begin
                    n_fc    = r_fc - FCW'(1);
                    n_state = S_RAPPH;
                end
            end

            S_RAPPH: begin
                if (r_sh) begin
                    fl_we      = 1'b1;
                    fl_waddr   = r_fc[FIW-1:0];
                    fl_wdata.x = '0;
                    fl_wdata.y = r_blk.y + r_h;
                    fl_wdata.w = w_eff_w;
                    fl_wdata.h = r_blk.h - r_h;
                    n_fc       = r_fc + FCW'(1);
                end
                n_state = S_RAPPV;
            end

            S_RAPPV: begin
                if (r_sv) begin
                    fl_we      = 1'b1;
                    fl_waddr   = r_fc[FIW-1:0];
                    fl_wdata.x = XW'(r_blk.x + XW'(r_w));
                    fl_wdata.y = r_blk.y;
                    fl_wdata.w = r_blk.w - r_w;
                    fl_wdata.h = r_gh;
                    n_fc       = r_fc + FCW'(1);
                end
                n_state = S_RROWH;
            end

            // row below the height split starts empty
            S_RROWH: begin
                if (r_sh) begin
                    rw_we        = 1'b1;
                    rw_waddr     = r_rh_ok ? r_rh_idx : r_ru[WIW-1:0];
                    rw_wdata.y   = r_blk.y + r_h;
                    rw_wdata.cnt = '0;
                    if (!r_rh_ok) begin
                        n_ru = r_ru + UCW'(1);
                    end
                end
                n_state = S_RROWB;
            end

            // count the reservation in its row, record it, report
            S_RROWB: begin
                rw_we        = 1'b1;
                rw_waddr     = r_rb_ok ? r_rb_idx : r_ru[WIW-1:0];
                rw_wdata.y   = r_blk.y;
                rw_wdata.cnt = (r_rb_ok && !r_addnew) ? r_rb_cnt + CW'(1) : CW'(1);
                if (!r_rb_ok) begin
                    n_ru = r_ru + UCW'(1);
                end
                rs_we      = 1'b1;
                rs_waddr   = r_slot;
                rs_wdata.x = r_blk.x;
                rs_wdata.y = r_blk.y;
                rs_wdata.w = r_gw;
                rs_wdata.h = r_gh;
                n_valid[r_slot] = 1'b1;
                if (v_top > {1'b0, r_hi}) begin
                    n_hi = HW'(v_top);
                end
                if (r_grew) begin
                    v_st = (r_gh < r_h) ? ST_LIMIT : ST_GREW;
                end
                n_res    = res_make(r_blk.x, r_blk.y, r_gh, r_cur_h, v_st);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            S_FSCAN: begin
                if (r_dv && !r_hit_ok && r_valid[r_dptr[RIW-1:0]] &&
                    rs_rd.x == r_ax && rs_rd.y == r_ay) begin
                    n_hit_ok  = 1'b1;
                    n_hit_idx = r_dptr[RIW-1:0];
                    n_hit     = rs_rd;
                end
                if (w_done) begin
                    n_state = S_FDEC;
                end
            end

            S_FDEC: begin
                if (!r_hit_ok) begin
                    n_res    = res_make('0, '0, '0, r_cur_h, ST_UNKNOWN);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_fc >= FCW'(FREE_ENTRIES)) begin
                    n_res    = res_make('0, '0, '0, r_cur_h, ST_FULL);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    fl_we      = 1'b1;
                    fl_waddr   = r_fc[FIW-1:0];
                    fl_wdata   = r_hit;
                    n_fc       = r_fc + FCW'(1);
                    n_valid[r_hit_idx] = 1'b0;
                    n_ptr      = '0;
                    n_dv       = 1'b0;
                    n_rb_ok    = 1'b0;
                    n_state    = S_FROW;
                end
            end

            S_FROW: begin
                if (r_dv && !r_rb_ok && rw_rd.y == r_ay) begin
                    n_rb_ok  = 1'b1;
                    n_rb_idx = r_dptr[WIW-1:0];
                    n_rb_cnt = rw_rd.cnt;
                end
                if (w_done) begin
                    n_state = S_FROWD;
                end
            end

            S_FROWD: begin
                n_res    = res_make(r_ax, r_ay, r_hit.h, r_cur_h, ST_OK);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_rb_ok && r_rb_cnt != '0) begin
                    rw_we        = 1'b1;
                    rw_waddr     = r_rb_idx;
                    rw_wdata.y   = r_ay;
                    rw_wdata.cnt = r_rb_cnt - CW'(1);
                    if (r_rb_cnt == CW'(1)) begin
                        // row emptied: merge its free blocks
                        n_strobe = 1'b0;
                        n_ptr    = '0;
                        n_dv     = 1'b0;
                        n_wr     = '0;
                        n_rowh   = '0;
                        n_state  = S_FCMP;
                    end
                end
            end

            // drop the row's blocks, keep the rest in order
            S_FCMP: begin
                if (r_dv) begin
                    if (fl_rd.y == r_ay) begin
                        n_rowh = fl_rd.h;
                    end else begin
                        fl_we    = 1'b1;
                        fl_waddr = r_wr[FIW-1:0];
                        fl_wdata = fl_rd;
                        n_wr     = r_wr + FCW'(1);
                    end
                end
                if (w_done) begin
                    n_fc    = r_wr;
                    n_state = S_FAPP;
                end
            end

            S_FAPP: begin
                fl_we      = 1'b1;
                fl_waddr   = r_fc[FIW-1:0];
                fl_wdata.x = '0;
                fl_wdata.y = r_ay;
                fl_wdata.w = w_eff_w;
                fl_wdata.h = r_rowh;
                n_fc       = r_fc + FCW'(1);
                n_res      = res_make(r_ax, r_ay, r_hit.h, r_cur_h, ST_OK);
                n_strobe   = 1'b1;
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_atlas_w <= ATLAS_W_RST;
            r_init_h  <= INIT_H_RST;
            r_fc      <= FCW'(1);
            r_ru      <= UCW'(1);
            r_valid   <= '0;
            r_hi      <= '0;
            r_cur_h   <= HW'(1);
            r_strobe  <= 1'b0;
            r_dv      <= 1'b0;
            r_clr_out <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_atlas_w <= n_atlas_w;
            r_init_h  <= n_init_h;
            r_fc      <= n_fc;
            r_ru      <= n_ru;
            r_valid   <= n_valid;
            r_hi      <= n_hi;
            r_cur_h   <= n_cur_h;
            r_strobe  <= n_strobe;
            r_dv      <= n_dv;
            r_clr_out <= n_clr_out;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_w       <= n_w;       r_h       <= n_h;       r_ax      <= n_ax;
        r_ay      <= n_ay;      r_ptr     <= n_ptr;     r_dptr    <= n_dptr;
        r_fit_ok  <= n_fit_ok;  r_fit_idx <= n_fit_idx; r_fit     <= n_fit;
        r_ext_ok  <= n_ext_ok;  r_ext_idx <= n_ext_idx; r_ext     <= n_ext;
        r_blk     <= n_blk;     r_idx     <= n_idx;     r_newh    <= n_newh;
        r_grew    <= n_grew;    r_addnew  <= n_addnew;  r_sh      <= n_sh;
        r_sv      <= n_sv;      r_gh      <= n_gh;      r_gw      <= n_gw;
        r_rb_ok   <= n_rb_ok;   r_rb_idx  <= n_rb_idx;  r_rb_cnt  <= n_rb_cnt;
        r_rh_ok   <= n_rh_ok;   r_rh_idx  <= n_rh_idx;
        r_vptr    <= n_vptr;    r_vdone   <= n_vdone;
        r_slot_ok <= n_slot_ok; r_slot    <= n_slot;
        r_hit_ok  <= n_hit_ok;  r_hit_idx <= n_hit_idx; r_hit     <= n_hit;
        r_rowh    <= n_rowh;    r_wr      <= n_wr;      r_res     <= n_res;
    end

    // a config write in the same cycle holds off a start
    assign busy            = (r_state != S_IDLE) || i_cfg_we;
    assign o_strobe        = r_strobe;
    assign o_block_x       = r_res.x;
    assign o_block_y       = r_res.y;
    assign o_block_height  = r_res.h;
    assign o_buffer_height = r_res.bh;
    assign o_status        = r_res.st;

    // the free list may be empty after a whole-buffer reserve
    `SAA_ASSERT(a_fc_range, r_fc <= FCW'(FREE_ENTRIES), "free count out of range")
    `SAA_ASSERT(a_ru_range, r_ru != '0 && r_ru <= UCW'(ROW_ENTRIES), "row count out of range")
    `SAA_ASSERT(a_height_range, r_cur_h != '0 && r_cur_h <= HW'(MAX_HEIGHT), "bad height")
    `SAA_NEVER(a_strobe_busy, o_strobe && r_state != S_IDLE, "result while sequencer busy")

endmodule

// ===== rtl/saa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saa_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module saa_ram
    import saa_pkg::*;
#(
    parameter int WIDTH = BLK_W,
    parameter int DEPTH = DEF_FREE_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shelf atlas allocator. A short directed table
// covers the extremes, every opcode, growth, the height limit and unknown
// frees; random phases then run many reserve/free/clear sequences under
// several buffer sizes. Every transfer is checked against a typed-in result
// or an in-bench model of the free list, reserved table and row counts.
// ----------------------------------------------------------------------------
module testbench;
    import saa_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;     // unused opcode, must be a no-op
    localparam int NFREE = DEF_FREE_ENTRIES;
    localparam int NRSV  = DEF_RESERVED_ENTRIES;
    localparam int NROW  = DEF_ROW_ENTRIES;
    localparam int HMAX  = DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [11:0] bx;
        logic [13:0] by;
        logic [14:0] bh;
        logic [14:0] buf_h;
        logic [2:0]  st;
    } t_alloc_result;

    typedef struct {
        logic [1:0]    op;
        logic [12:0]   w;
        logic [14:0]   h;
        logic [11:0]   ax;
        logic [13:0]   ay;
        bit            known;      // expected result typed in below
        t_alloc_result res;
    } t_cmd;

    typedef struct { int unsigned x, y, w, h; } t_rect;
    typedef struct { bit valid; int unsigned x, y, w, h; } t_grant;
    typedef struct { int unsigned y, cnt; } t_shelf;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [12:0] i_req_width = '0;
    logic [14:0] i_req_height = '0;
    logic [11:0] i_addr_x = '0;
    logic [13:0] i_addr_y = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [14:0] i_cfg_data = '0;
    logic        o_strobe;
    logic [11:0] o_block_x;
    logic [13:0] o_block_y;
    logic [14:0] o_block_height;
    logic [14:0] o_buffer_height;
    logic [2:0]  o_status;

    shelf_atlas_allocator_top DUT (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Allocator model: own copy of configuration and tables
    // ------------------------------------------------------------------
    int unsigned   cfg_width, cfg_height;
    t_rect         shelf_free[NFREE];
    int unsigned   n_free;
    t_grant        grants[NRSV];
    t_shelf        shelves[NROW];
    int unsigned   n_shelves;
    int unsigned   top_reserved, buf_height;

    t_alloc_result pending_results[$];
    int            n_errors = 0;

    function automatic int unsigned width_used();
        if (cfg_width == 0) return 1;
        return (cfg_width > 4096) ? 4096 : cfg_width;
    endfunction

    function automatic void atlas_clear();
        foreach (grants[i]) grants[i] = '{0, 0, 0, 0, 0};
        foreach (shelves[i]) shelves[i] = '{0, 0};
        foreach (shelf_free[i]) shelf_free[i] = '{0, 0, 0, 0};
        buf_height = (cfg_height == 0) ? 1 : ((cfg_height > HMAX) ? HMAX : cfg_height);
        shelf_free[0] = '{0, 0, width_used(), buf_height};
        n_free = 1;
        n_shelves = 1;
        top_reserved = 0;
    endfunction

    function automatic int shelf_find(int unsigned y);
        for (int i = 0; i < n_shelves && i < NROW; i++)
            if (shelves[i].y == y) return i;
        return -1;
    endfunction

    function automatic void shelf_zero(int unsigned y);
        int r;
        r = shelf_find(y);
        if (r >= 0) begin
            shelves[r].cnt = 0;
        end else if (n_shelves < NROW) begin
            shelves[n_shelves] = '{y, 0};
            n_shelves++;
        end
    endfunction

    function automatic void free_remove(int unsigned i);
        if (i >= n_free) return;
        for (int k = i; k + 1 < n_free; k++) shelf_free[k] = shelf_free[k + 1];
        n_free--;
    endfunction

    function automatic void free_append(int unsigned x, y, w, h);
        if (n_free >= NFREE) return;
        shelf_free[n_free] = '{x, y, w, h};
        n_free++;
    endfunction

    function automatic t_alloc_result pack_result(int unsigned x, y, h, logic [2:0] st);
        t_alloc_result r;
        r.bx = x[11:0];
        r.by = y[13:0];
        r.bh = h[14:0];
        r.buf_h = buf_height[14:0];
        r.st = st;
        return r;
    endfunction

    function automatic t_alloc_result atlas_reserve(int unsigned rw, int unsigned rh);
        int unsigned wd, w, h, bx, by, bw, bh, newh, delta, gh, gw, need_f, need_r;
        int idx, ext, slot, r;
        bit grew, addnew, sh, sv;
        wd = width_used();
        w = (rw == 0) ? 1 : ((rw > wd) ? wd : rw);
        h = (rh == 0) ? 1 : rh;
        idx = -1; ext = -1; slot = -1;
        grew = 0; addnew = 0; newh = buf_height;
        bx = 0; by = 0; bw = 0; bh = 0;
        for (int i = 0; i < n_free; i++)
            if (shelf_free[i].w >= w && shelf_free[i].h >= h) begin
                idx = i;
                break;
            end
        if (idx >= 0) begin
            bx = shelf_free[idx].x; by = shelf_free[idx].y;
            bw = shelf_free[idx].w; bh = shelf_free[idx].h;
        end else begin
            newh = buf_height + buf_height / 4;
            if (newh > HMAX) newh = HMAX;
            delta = newh - buf_height;
            for (int i = 0; i < n_free; i++)
                if (shelf_free[i].x == 0 && shelf_free[i].w == wd &&
                    shelf_free[i].y + shelf_free[i].h == buf_height) begin
                    ext = i;
                    break;
                end
            if (ext >= 0) begin
                idx = ext;
                by = shelf_free[ext].y; bw = wd; bh = shelf_free[ext].h + delta;
            end else if (delta > 0) begin
                addnew = 1;
                by = top_reserved; bw = wd; bh = delta;
            end else begin
                return pack_result(0, 0, 0, ST_LIMIT);
            end
            grew = 1;
        end
        // full-width blocks at x 0 split by height, then anything wider by width
        sh = (bh > h && bx == 0 && bw == wd);
        sv = (bw > w);
        gh = sh ? h : bh;
        gw = sv ? w : bw;
        need_f = n_free + sh + sv - (addnew ? 0 : 1);
        need_r = 0;
        if (shelf_find(by) < 0) need_r++;
        if (sh && shelf_find(by + h) < 0) need_r++;
        for (int i = 0; i < NRSV; i++)
            if (!grants[i].valid) begin
                slot = i;
                break;
            end
        if (need_f > NFREE || n_shelves + need_r > NROW || slot < 0)
            return pack_result(0, 0, 0, ST_FULL);
        buf_height = newh;
        if (!addnew) free_remove(idx);
        if (sh) free_append(0, by + h, wd, bh - h);
        if (sv) free_append(bx + w, by, bw - w, gh);
        if (addnew) shelf_zero(by);
        if (sh) shelf_zero(by + h);
        if (shelf_find(by) < 0) shelf_zero(by);
        r = shelf_find(by);
        if (r >= 0) shelves[r].cnt++;
        grants[slot] = '{1, bx, by, gw, gh};
        if (by + gh > top_reserved) top_reserved = by + gh;
        return pack_result(bx, by, gh, grew ? ((gh < h) ? ST_LIMIT : ST_GREW) : ST_OK);
    endfunction

    function automatic t_alloc_result atlas_free(int unsigned ax, int unsigned ay);
        int s, r;
        int unsigned fh, rowh, i;
        s = -1;
        for (int k = 0; k < NRSV; k++)
            if (grants[k].valid && grants[k].x == ax && grants[k].y == ay) begin
                s = k;
                break;
            end
        if (s < 0) return pack_result(0, 0, 0, ST_UNKNOWN);
        if (n_free >= NFREE) return pack_result(0, 0, 0, ST_FULL);
        fh = grants[s].h;
        free_append(grants[s].x, grants[s].y, grants[s].w, fh);
        grants[s].valid = 0;
        r = shelf_find(ay);
        if (r >= 0 && shelves[r].cnt > 0) begin
            shelves[r].cnt--;
            // last block of the shelf gone: fold its free pieces into one
            if (shelves[r].cnt == 0) begin
                rowh = 0;
                i = 0;
                while (i < n_free) begin
                    if (shelf_free[i].y == ay) begin
                        rowh = shelf_free[i].h;
                        free_remove(i);
                    end else begin
                        i++;
                    end
                end
                free_append(0, ay, width_used(), rowh);
            end
        end
        return pack_result(ax, ay, fh, ST_OK);
    endfunction

    function automatic t_alloc_result atlas_step(t_cmd c);
        case (c.op)
            OP_RESERVE: return atlas_reserve(c.w, c.h);
            OP_FREE:    return atlas_free(c.ax, c.ay);
            OP_CLEAR: begin
                atlas_clear();
                return pack_result(0, 0, 0, ST_OK);
            end
            default:    return pack_result(0, 0, 0, ST_OK);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking: each strobe is compared with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_alloc_result e;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_block_x !== e.bx) begin
                    $error("block_x: expected %0d, got %0d", e.bx, o_block_x);
                    n_errors++;
                end
                if (o_block_y !== e.by) begin
                    $error("block_y: expected %0d, got %0d", e.by, o_block_y);
                    n_errors++;
                end
                if (o_block_height !== e.bh) begin
                    $error("block_height: expected %0d, got %0d", e.bh, o_block_height);
                    n_errors++;
                end
                if (o_buffer_height !== e.buf_h) begin
                    $error("buffer_height: expected %0d, got %0d", e.buf_h, o_buffer_height);
                    n_errors++;
                end
                if (o_status !== e.st) begin
                    $error("status: expected %0d, got %0d", e.st, o_status);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: generous bound on the whole run.
    int unsigned n_cycles = 0;
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    // One command transfer. Start stays high across back-to-back commands;
    // between bursts the sender drops start for a random gap.
    task automatic issue(t_cmd c);
        t_alloc_result p;
        if (burst_left == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end else begin
            @(negedge i_clk);
        end
        burst_left--;
        start        <= 1'b1;
        i_opcode     <= c.op;
        i_req_width  <= c.w;
        i_req_height <= c.h;
        i_addr_x     <= c.ax;
        i_addr_y     <= c.ay;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        p = atlas_step(c);
        pending_results.insert(pending_results.size(), c.known ? c.res : p);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Register write only with the block idle; each write also clears it.
    task automatic cfg_write(logic idx, logic [14:0] data);
        drain();
        while (busy) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ATLAS_WIDTH) cfg_width = data[12:0];
        else cfg_height = data;
        atlas_clear();
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    function automatic t_cmd mk(logic [1:0] op, int unsigned w, h, ax, ay);
        t_cmd c;
        c.op = op; c.w = w[12:0]; c.h = h[14:0]; c.ax = ax[11:0]; c.ay = ay[13:0];
        c.known = 0;
        c.res = '{0, 0, 0, 0, ST_OK};
        return c;
    endfunction

    function automatic t_cmd mk_known(t_cmd c, int unsigned bx, by, bh, bufh,
                                      logic [2:0] st);
        c.known = 1;
        c.res = '{bx[11:0], by[13:0], bh[14:0], bufh[14:0], st};
        return c;
    endfunction

    // Random command: mostly well-formed reserve/free traffic, some noise.
    function automatic t_cmd random_cmd();
        int unsigned sel, live[$];
        t_cmd c;
        sel = $urandom_range(0, 99);
        c = mk(OP_RESERVE, $urandom_range(1, 200), $urandom_range(1, 120),
               $urandom(), $urandom());
        if (sel < 8) begin
            c.w = 13'($urandom());
            c.h = 15'($urandom());
        end else if (sel < 15) begin
            c.h = 15'($urandom_range(1, 2000));
        end else if (sel < 52) begin
            // well-formed reserve, already set
        end else if (sel < 88) begin
            c.op = OP_FREE;
            foreach (grants[i]) if (grants[i].valid) live.insert(live.size(), i);
            if (live.size() != 0 && sel < 84) begin
                sel = live[$urandom_range(0, live.size() - 1)];
                c.ax = grants[sel].x[11:0];
                c.ay = grants[sel].y[13:0];
            end
        end else if (sel < 91) begin
            c.op = OP_CLEAR;
        end else if (sel < 94) begin
            c.op = OP_NOP;
        end else begin
            c.op = 2'($urandom());
            c.w = 13'($urandom());
            c.h = 15'($urandom());
        end
        return c;
    endfunction

    t_cmd        directed[$];
    int unsigned phase_w[7] = '{1024, 0, 4096, 8191, 300, 1, 64};
    int unsigned phase_h[7] = '{1024, 64, 16384, 0, 32767, 1, 100};

    function automatic void add_row(t_cmd c);
        directed.insert(directed.size(), c);
    endfunction

    initial begin
        cfg_width = ATLAS_W_RST;
        cfg_height = INIT_H_RST;
        atlas_clear();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);

        // Directed part on the reset geometry, 1024 x 1024.
        // Oversized request: clipped width, growth by a quarter falls short.
        add_row(mk_known(mk(OP_RESERVE, 13'h1FFF, 15'h7FFF, 0, 0),
                         0, 0, 1280, 1280, ST_LIMIT));
        add_row(mk_known(mk(OP_FREE, 0, 0, 0, 0), 0, 0, 1280, 1280, ST_OK));
        add_row(mk_known(mk(OP_FREE, 0, 0, 4095, 16383), 0, 0, 0, 1280,
                         ST_UNKNOWN));
        add_row(mk_known(mk(OP_CLEAR, 13'h1FFF, 15'h7FFF, 4095, 16383),
                         0, 0, 0, 1024, ST_OK));
        add_row(mk_known(mk(OP_NOP, 13'h1FFF, 15'h7FFF, 4095, 16383),
                         0, 0, 0, 1024, ST_OK));
        // zero size is taken as 1 x 1
        add_row(mk_known(mk(OP_RESERVE, 0, 0, 0, 0), 0, 0, 1, 1024, ST_OK));
        add_row(mk(OP_RESERVE, 1024, 1, 0, 0));
        add_row(mk(OP_RESERVE, 4096, 16384, 0, 0));
        add_row(mk(OP_RESERVE, 5, 5, 0, 0));
        add_row(mk(OP_RESERVE, 100, 2000, 0, 0));   // growth
        add_row(mk(OP_FREE, 0, 0, 0, 0));
        add_row(mk(OP_FREE, 0, 0, 0, 1));
        add_row(mk(OP_FREE, 0, 0, 1, 0));
        add_row(mk(OP_RESERVE, 1, 16384, 0, 0));
        add_row(mk(OP_RESERVE, 700, 30, 0, 0));
        add_row(mk(OP_RESERVE, 700, 30, 0, 0));      // no room beside, next row
        add_row(mk(OP_FREE, 0, 0, 0, 2));
        add_row(mk(OP_CLEAR, 0, 0, 0, 0));
        add_row(mk(OP_NOP, 0, 0, 0, 0));
        foreach (directed[i]) issue(directed[i]);

        // Random phases, each under its own geometry, extremes included.
        for (int ph = 0; ph < 7; ph++) begin
            cfg_write(CFG_ATLAS_WIDTH, 15'(phase_w[ph]));
            cfg_write(CFG_INIT_HEIGHT, 15'(phase_h[ph]));
            repeat (120) issue(random_cmd());
        end

        drain();
        repeat (400) @(negedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
